@@ rtl/core/c2z_pkg.sv @@
// Shared types and constants for the zero-padded same-size 2D convolution block.
package c2z_pkg;

	localparam int CMD_W       = 2;
	localparam int ROW_W       = 5;
	localparam int VALUE_W     = 16;
	localparam int SUM_W       = 38;
	localparam int ISIZE_W     = 6;
	localparam int KSIZE_W     = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;
	// signed tap coordinate: row (5b) + kernel index (<15) - offset, with sign
	localparam int COORD_W     = 8;

	localparam logic [ISIZE_W-1:0] ISIZE_RESET = 6'd32;
	localparam logic [KSIZE_W-1:0] KSIZE_RESET = 4'd9;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_KERNEL = 2'd0,
		CMD_LOAD_IMAGE  = 2'd1,
		CMD_COMPUTE     = 2'd2
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_SIZE  = 2'd0,
		REG_KERNEL_SIZE = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_RUN    = 3'd1,
		ST_DRAIN1 = 3'd2,
		ST_DRAIN2 = 3'd3,
		ST_DONE   = 3'd4
	} seq_state_t;

	typedef struct packed {
		logic busy;
		logic clr;
		logic tap_s1;
		logic result_load;
	} seq_ctl_t;

endpackage

@@ rtl/core/c2z_mem.sv @@
// Single write port, single registered read port sample memory.
module c2z_mem #(
	parameter int DEPTH = 1024,
	parameter int DW    = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic signed [DW-1:0] wr_data,
	input  logic [AW-1:0]        rd_addr,
	output logic signed [DW-1:0] rd_data
);

	logic signed [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ rtl/core/c2z_mac.sv @@
// Shared multiply-accumulate unit: one tap per cycle, product registered before the add.
module c2z_mac #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  c2z_pkg::seq_ctl_t              ctl,
	input  logic signed [SAMPLE_BITS-1:0]  pix,
	input  logic signed [SAMPLE_BITS-1:0]  coef,
	output logic signed [c2z_pkg::SUM_W-1:0] acc
);

	logic signed [2*SAMPLE_BITS-1:0]    prod_s2;
	logic                               tap_s2;
	logic signed [c2z_pkg::SUM_W-1:0]   acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s2 <= 1'b0;
		end else begin
			tap_s2 <= ctl.tap_s1;
		end
	end

	// only in-range taps are multiplied; padding taps outside the image never reach the sum
	always_ff @(posedge clk) begin
		if (ctl.tap_s1) begin
			prod_s2 <= pix * coef;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (tap_s2) begin
			acc_q <= acc_q + c2z_pkg::SUM_W'(prod_s2);
		end
	end

	assign acc = acc_q;

endmodule

@@ rtl/core/c2z_seq.sv @@
// Tap sequencer: walks the kernel window, generates store addresses and MAC controls.
module c2z_seq #(
	parameter int MAX_IMAGE  = 32,
	parameter int MAX_KERNEL = 9,
	localparam int IDEPTH    = MAX_IMAGE * MAX_IMAGE,
	localparam int KDEPTH    = MAX_KERNEL * MAX_KERNEL,
	localparam int IA_W      = (IDEPTH > 1) ? $clog2(IDEPTH) : 1,
	localparam int KA_W      = (KDEPTH > 1) ? $clog2(KDEPTH) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [c2z_pkg::ROW_W-1:0]       row,
	input  logic [c2z_pkg::ROW_W-1:0]       col,
	input  logic [c2z_pkg::ISIZE_W-1:0]     image_size,
	input  logic [c2z_pkg::KSIZE_W-1:0]     kernel_size,
	input  logic                            out_free,
	output logic [IA_W-1:0]                 img_addr,
	output logic [KA_W-1:0]                 ker_addr,
	output c2z_pkg::seq_ctl_t               ctl
);

	localparam int IW = (MAX_IMAGE > 1) ? $clog2(MAX_IMAGE) : 1;
	localparam int KW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

	c2z_pkg::seq_state_t state_q, state_d;

	logic [c2z_pkg::ROW_W-1:0]    row_q, col_q;
	logic [c2z_pkg::ISIZE_W-1:0]  w_q;
	logic [c2z_pkg::KSIZE_W-1:0]  k_q;
	logic [c2z_pkg::KSIZE_W-1:0]  off_q;
	logic [KW-1:0]                kr_q, kc_q;
	logic                         tap_s1;

	logic [c2z_pkg::ISIZE_W-1:0]  w_eff;
	logic [c2z_pkg::KSIZE_W-1:0]  k_eff;
	logic [c2z_pkg::COORD_W-1:0]  ir, ic;
	logic                         ir_ok, ic_ok;
	logic                         col_last, row_last, last_tap;
	logic                         issue;

	// sizes above the store limits act as the limit
	assign w_eff = (image_size > MAX_IMAGE) ? c2z_pkg::ISIZE_W'(MAX_IMAGE) : image_size;
	assign k_eff = (kernel_size > MAX_KERNEL) ? c2z_pkg::KSIZE_W'(MAX_KERNEL) : kernel_size;

	// two's complement coordinates, bit 7 is the sign
	assign ir = c2z_pkg::COORD_W'(row_q) + c2z_pkg::COORD_W'(kr_q) - c2z_pkg::COORD_W'(off_q);
	assign ic = c2z_pkg::COORD_W'(col_q) + c2z_pkg::COORD_W'(kc_q) - c2z_pkg::COORD_W'(off_q);
	assign ir_ok = !ir[c2z_pkg::COORD_W-1] && (ir < c2z_pkg::COORD_W'(w_q));
	assign ic_ok = !ic[c2z_pkg::COORD_W-1] && (ic < c2z_pkg::COORD_W'(w_q));

	assign img_addr = IA_W'(ir[IW-1:0] * MAX_IMAGE + ic[IW-1:0]);
	assign ker_addr = KA_W'(kr_q * MAX_KERNEL + kc_q);

	assign col_last = (c2z_pkg::KSIZE_W'(kc_q) == k_q - 4'd1);
	assign row_last = (c2z_pkg::KSIZE_W'(kr_q) == k_q - 4'd1);
	assign last_tap = col_last && row_last;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			c2z_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (k_eff == '0) ? c2z_pkg::ST_DRAIN1 : c2z_pkg::ST_RUN;
				end
			end
			c2z_pkg::ST_RUN: begin
				if (last_tap) begin
					state_d = c2z_pkg::ST_DRAIN1;
				end
			end
			c2z_pkg::ST_DRAIN1: state_d = c2z_pkg::ST_DRAIN2;
			c2z_pkg::ST_DRAIN2: state_d = c2z_pkg::ST_DONE;
			c2z_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = c2z_pkg::ST_IDLE;
				end
			end
			default: state_d = c2z_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.busy        = (state_q != c2z_pkg::ST_IDLE);
		ctl.clr         = (state_q == c2z_pkg::ST_IDLE) && start;
		ctl.tap_s1      = tap_s1;
		ctl.result_load = (state_q == c2z_pkg::ST_DONE) && out_free;
		issue           = (state_q == c2z_pkg::ST_RUN) && ir_ok && ic_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c2z_pkg::ST_IDLE;
			tap_s1  <= 1'b0;
			kr_q    <= '0;
			kc_q    <= '0;
		end else begin
			state_q <= state_d;
			tap_s1  <= issue;
			if (state_q == c2z_pkg::ST_IDLE) begin
				kr_q <= '0;
				kc_q <= '0;
			end else if (state_q == c2z_pkg::ST_RUN) begin
				if (col_last) begin
					kc_q <= '0;
					kr_q <= kr_q + 1'b1;
				end else begin
					kc_q <= kc_q + 1'b1;
				end
			end
		end
	end

	// job operands, captured when a compute transaction is taken
	always_ff @(posedge clk) begin
		if ((state_q == c2z_pkg::ST_IDLE) && start) begin
			row_q <= row;
			col_q <= col;
			w_q   <= w_eff;
			k_q   <= k_eff;
			off_q <= k_eff >> 1;
		end
	end

endmodule

@@ rtl/core/conv2d_zero_padded_same_top.sv @@
// Top level of the zero-padded same-size 2D convolution block.
// Loads (kernel coefficient or image pixel) never lower in_ready; in_ready stays high.
// A compute holds in_ready low from its transaction until its result is loaded: the
// sequencer walks the k*k kernel positions (k = active kernel size, none if 0) in RUN,
// then passes DRAIN1 and DRAIN2 and waits in DONE until the result slot is free. The
// shared multiply-accumulate unit takes one kernel tap per cycle. arst_n resets control and config.
module conv2d_zero_padded_same_top #(
	parameter int MAX_IMAGE   = 32,
	parameter int MAX_KERNEL  = 9,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// command channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [c2z_pkg::CMD_W-1:0]             command,
	input  logic [c2z_pkg::ROW_W-1:0]             row,
	input  logic [c2z_pkg::ROW_W-1:0]             col,
	input  logic signed [c2z_pkg::VALUE_W-1:0]    value,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [c2z_pkg::SUM_W-1:0]      sum,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [c2z_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [c2z_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int IDEPTH = MAX_IMAGE * MAX_IMAGE;
	localparam int KDEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int IA_W   = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
	localparam int KA_W   = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;

	logic [c2z_pkg::ISIZE_W-1:0]      image_size_q;
	logic [c2z_pkg::KSIZE_W-1:0]      kernel_size_q;

	logic                             in_acc;
	logic                             load_ker, load_img, start;
	logic [IA_W-1:0]                  img_wr_addr, img_rd_addr;
	logic [KA_W-1:0]                  ker_wr_addr, ker_rd_addr;
	logic signed [SAMPLE_BITS-1:0]    sample;
	logic signed [SAMPLE_BITS-1:0]    pix, coef;
	logic signed [c2z_pkg::SUM_W-1:0] acc;
	logic                             out_free;
	logic                             out_valid_q;
	logic signed [c2z_pkg::SUM_W-1:0] sum_q;
	c2z_pkg::seq_ctl_t                ctl;

	// ---- configuration: always writable, unknown indexes are dropped ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q  <= c2z_pkg::ISIZE_RESET;
			kernel_size_q <= c2z_pkg::KSIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				c2z_pkg::REG_IMAGE_SIZE:  image_size_q  <= cfg_data;
				c2z_pkg::REG_KERNEL_SIZE: kernel_size_q <= cfg_data[c2z_pkg::KSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- command decode ----
	// busy from a compute transaction until its result is loaded; loads go straight into the stores
	assign in_ready = !ctl.busy;
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		load_ker = 1'b0;
		load_img = 1'b0;
		start    = 1'b0;
		unique case (command)
			c2z_pkg::CMD_LOAD_KERNEL: load_ker = in_acc && (row < MAX_KERNEL) && (col < MAX_KERNEL);
			c2z_pkg::CMD_LOAD_IMAGE:  load_img = in_acc && (row < MAX_IMAGE) && (col < MAX_IMAGE);
			c2z_pkg::CMD_COMPUTE:     start    = in_acc;
			default: ; // unused code: transaction taken, nothing happens
		endcase
	end

	// incoming value wraps or sign-extends to the stored sample width
	assign sample      = SAMPLE_BITS'(value);
	assign img_wr_addr = IA_W'(row * MAX_IMAGE + col);
	assign ker_wr_addr = KA_W'(row * MAX_KERNEL + col);

	// ---- sample stores ----
	c2z_mem #(
		.DEPTH (IDEPTH),
		.DW    (SAMPLE_BITS)
	) u_img_mem (
		.clk     (clk),
		.wr_en   (load_img),
		.wr_addr (img_wr_addr),
		.wr_data (sample),
		.rd_addr (img_rd_addr),
		.rd_data (pix)
	);

	c2z_mem #(
		.DEPTH (KDEPTH),
		.DW    (SAMPLE_BITS)
	) u_ker_mem (
		.clk     (clk),
		.wr_en   (load_ker),
		.wr_addr (ker_wr_addr),
		.wr_data (sample),
		.rd_addr (ker_rd_addr),
		.rd_data (coef)
	);

	// ---- tap sequencer and shared MAC ----
	c2z_seq #(
		.MAX_IMAGE  (MAX_IMAGE),
		.MAX_KERNEL (MAX_KERNEL)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.row         (row),
		.col         (col),
		.image_size  (image_size_q),
		.kernel_size (kernel_size_q),
		.out_free    (out_free),
		.img_addr    (img_rd_addr),
		.ker_addr    (ker_rd_addr),
		.ctl         (ctl)
	);

	c2z_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pix    (pix),
		.coef   (coef),
		.acc    (acc)
	);

	// ---- result register ----
	// the finished sum waits in DONE until the slot is empty or being emptied
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.result_load) begin
			sum_q <= acc;
		end
	end

	assign out_valid = out_valid_q;
	assign sum       = sum_q;

endmodule

@@ rtl/core/c2z_checker.sv @@
// Port-level checker for the convolution top level, bound to every instance.
module c2z_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic [c2z_pkg::CMD_W-1:0]          command,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [c2z_pkg::SUM_W-1:0]   sum
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sum))
		else $error("result changed while stalled");

	// a compute transaction makes the block busy
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command == c2z_pkg::CMD_COMPUTE) |=> !in_ready)
		else $error("ready after compute transaction");

	// anything but a compute completes in its own cycle
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command != c2z_pkg::CMD_COMPUTE) |=> in_ready)
		else $error("block busy after load transaction");

	// a new result only comes out of a compute in progress
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without compute");

endmodule

bind conv2d_zero_padded_same_top c2z_checker u_c2z_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.command   (command),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sum       (sum)
);
